FILE: hw/rtl/fsd_pkg.sv
// Shared types, constants and arithmetic helpers for the 1-bit error-diffusion ditherer.
package fsd_pkg;

  localparam int unsigned DefMaxWidth = 2048;

  localparam int unsigned ErrW   = 11;  // stored error width
  localparam int unsigned SumW   = 13;  // inverted pixel plus two errors
  localparam int unsigned CountW = 24;
  localparam int unsigned RowW   = 12;
  localparam int unsigned ThrW   = 8;

  localparam logic [RowW-1:0] RowWidthReset = 12'd2048;
  localparam logic [ThrW-1:0] ThresholdReset = 8'd128;
  localparam logic [7:0]      BitMsb         = 8'h80;
  localparam logic [7:0]      WhiteLevel     = 8'hFF;

  // register index as decoded from paddr[2]
  localparam logic RegRowWidth = 1'b0;
  localparam logic RegThreshold = 1'b1;

  // write side of the error line store
  typedef struct packed {
    logic                   mem_we;
    logic                   tail_we;
    logic signed [ErrW-1:0] mem_data;
    logic signed [ErrW-1:0] tail_data;
  } err_wr_t;

  // e * k / 16 truncated toward zero; |e| stays below 4096
  function automatic logic signed [ErrW-1:0] share(input logic signed [SumW-1:0] e,
                                                   input logic [2:0] k);
    logic [SumW-1:0] mag;
    logic [14:0]     prod;
    logic [ErrW-1:0] q;
    mag  = e[SumW-1] ? (~e + 1'b1) : e;
    prod = mag[11:0] * k;
    q    = prod[14:4];
    return e[SumW-1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [ErrW-1:0] clamp_err(input logic signed [ErrW:0] v);
    if (v > $signed(12'sd1023)) begin
      return 11'sd1023;
    end else if (v < $signed(-12'sd1024)) begin
      return -11'sd1024;
    end
    return v[ErrW-1:0];
  endfunction

endpackage

FILE: hw/rtl/fsd_line_store.sv
// Error line memory for the next row, with a last-column register and write forwarding.
module fsd_line_store import fsd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DefMaxWidth,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_en_i,
  input  logic [CW-1:0]          rd_addr_i,
  input  err_wr_t                wr_i,
  input  logic [CW-1:0]          mem_addr_i,
  input  logic [CW-1:0]          tail_addr_i,
  output logic signed [ErrW-1:0] above_o
);

  logic signed [ErrW-1:0] mem [MAX_WIDTH];
  logic signed [ErrW-1:0] mem_rd_q;

  logic                   tail_vld_q, tail_vld_d;
  logic [CW-1:0]          tail_addr_q;
  logic signed [ErrW-1:0] tail_data_q;

  logic                   byp_hit_q, byp_hit_d;
  logic signed [ErrW-1:0] byp_data_q, byp_data_d;

  always_ff @(posedge clk_i) begin
    if (wr_i.mem_we) begin
      mem[mem_addr_i] <= wr_i.mem_data;
    end
    if (rd_en_i) begin
      mem_rd_q <= mem[rd_addr_i];
    end
  end

  // Newest write wins: this cycle's writes, then the held last-column entry.
  always_comb begin
    byp_hit_d  = 1'b0;
    byp_data_d = wr_i.mem_data;
    if (wr_i.mem_we && mem_addr_i == rd_addr_i) begin
      byp_hit_d  = 1'b1;
      byp_data_d = wr_i.mem_data;
    end else if (wr_i.tail_we && tail_addr_i == rd_addr_i) begin
      byp_hit_d  = 1'b1;
      byp_data_d = wr_i.tail_data;
    end else if (tail_vld_q && tail_addr_q == rd_addr_i) begin
      byp_hit_d  = 1'b1;
      byp_data_d = tail_data_q;
    end
  end

  always_comb begin
    tail_vld_d = tail_vld_q;
    if (wr_i.tail_we) begin
      tail_vld_d = 1'b1;
    end else if (wr_i.mem_we && mem_addr_i == tail_addr_q) begin
      tail_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_vld_q <= 1'b0;
      byp_hit_q  <= 1'b0;
    end else begin
      tail_vld_q <= tail_vld_d;
      if (rd_en_i) begin
        byp_hit_q <= byp_hit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.tail_we) begin
      tail_addr_q <= tail_addr_i;
      tail_data_q <= wr_i.tail_data;
    end
    if (rd_en_i) begin
      byp_data_q <= byp_data_d;
    end
  end

  assign above_o = byp_hit_q ? byp_data_q : mem_rd_q;

endmodule

FILE: hw/rtl/floyd_steinberg_dither_1bit_unit.sv
// Top level of the 8-bit grey to 1-bit packed error-diffusion ditherer.
// Usage:
//   Pixels enter on the s_axis channel in raster order, pixel in tdata, start-of-image
//   flag in tuser. Packed bytes leave on m_axis: eight pixels per byte, first pixel in
//   bit 7, plus the running count of one (white) pixels; tlast marks the last byte of
//   a row, which is zero padded. Row width and threshold are written over the APB port;
//   the user must write them only while the block is idle; the block does not enforce it.
// Timing:
//   One pixel per cycle sustained while m_axis is not stalled. A pixel is registered
//   together with its line store read at the edge that accepts it and is diffused from
//   those registers; the byte that a pixel completes is captured in the output register
//   when the diffusion stage takes that pixel. The diffusion loop (add, compare, shares)
//   is combinational; line store hazards for narrow rows are forwarded.
// Reset clears the packing, count and carries and marks the next row as first row,
//   so stored errors are not used until a row has been written.
// A stalled m_axis holds its transaction; the diffusion stage then holds and s_axis
//   drops tready until the output register drains. Nothing is dropped.
module floyd_steinberg_dither_1bit_unit import fsd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DefMaxWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic [0:0]  s_axis_tuser,   // [0] start_image
  // packed output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] packed_byte, [31:8] count of one (white) pixels
  output logic        m_axis_tlast    // row_end
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned XW = (WW > RowW) ? WW : RowW;

  // ---------------- configuration ----------------
  logic [RowW-1:0] row_width_q;
  logic [ThrW-1:0] threshold_q;
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= RowWidthReset;
      threshold_q <= ThresholdReset;
    end else if (cfg_we) begin
      case (paddr[2])
        RegRowWidth:  row_width_q <= pwdata[RowW-1:0];
        RegThreshold: threshold_q <= pwdata[ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegRowWidth:  prdata = {{(32-RowW){1'b0}}, row_width_q};
      RegThreshold: prdata = {{(32-ThrW){1'b0}}, threshold_q};
      default:      prdata = '0;
    endcase
  end

  // ---------------- input stage: column tracking and line read ----------------
  logic            s_fire, s1_fire;
  logic            in_start;
  logic [CW-1:0]   col_q, col_d, in_col;
  logic            first_q, first_d, in_first;
  logic [XW-1:0]   w_raw, w_eff;
  logic            in_last;

  logic            s1_vld_q;
  logic [7:0]      s1_pix_q;
  logic            s1_start_q, s1_first_q, s1_last_q;
  logic [CW-1:0]   s1_col_q;

  logic            out_vld_q;

  assign s1_fire       = s1_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !s1_vld_q || s1_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign in_start = s_axis_tuser[0];
  assign in_col   = in_start ? '0 : col_q;
  assign in_first = in_start || first_q;

  // zero acts as one, oversize acts as the line store depth
  always_comb begin
    w_raw = XW'(row_width_q);
    if (w_raw == '0) begin
      w_eff = XW'(1);
    end else if (w_raw > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
  end

  assign in_last = (XW'(in_col) + XW'(1)) >= w_eff;

  always_comb begin
    col_d   = col_q;
    first_d = first_q;
    if (s_fire) begin
      if (in_last) begin
        col_d   = '0;
        first_d = 1'b0;
      end else begin
        col_d   = in_col + 1'b1;
        first_d = in_first;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      first_q  <= 1'b1;
      s1_vld_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      first_q <= first_d;
      if (s_fire) begin
        s1_vld_q <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_pix_q   <= s_axis_tdata;
      s1_start_q <= in_start;
      s1_first_q <= in_first;
      s1_last_q  <= in_last;
      s1_col_q   <= in_col;
    end
  end

  // ---------------- diffusion stage ----------------
  err_wr_t                err_wr;
  logic [CW-1:0]          mem_addr;
  logic signed [ErrW-1:0] above_rd, above;

  logic signed [ErrW-1:0] rc_q, rc_d, bp0_q, bp0_d, bp1_q, bp1_d;
  logic signed [ErrW-1:0] rc, bp0, bp1;
  logic [7:0]             acc_q, acc_d, acc, acc_new;
  logic [2:0]             pos_q, pos_d, pos;
  logic [CountW-1:0]      cnt_q, cnt_d, cnt, cnt_new;

  logic signed [SumW-1:0] sum, err;
  logic                   bit_one, emit;
  logic signed [ErrW-1:0] p1, p3, p5, p7;
  logic signed [ErrW:0]   left_sum, cur_sum;
  logic signed [ErrW-1:0] cur;

  logic [7:0]             out_byte_q;
  logic                   out_last_q;
  logic [CountW-1:0]      out_cnt_q;

  fsd_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (s_fire),
    .rd_addr_i   (in_col),
    .wr_i        (err_wr),
    .mem_addr_i  (mem_addr),
    .tail_addr_i (s1_col_q),
    .above_o     (above_rd)
  );

  // start of image clears carries, packing and count before this pixel
  assign rc  = s1_start_q ? '0 : rc_q;
  assign bp0 = s1_start_q ? '0 : bp0_q;
  assign bp1 = s1_start_q ? '0 : bp1_q;
  assign acc = s1_start_q ? '0 : acc_q;
  assign pos = s1_start_q ? '0 : pos_q;
  assign cnt = s1_start_q ? '0 : cnt_q;

  assign above = s1_first_q ? '0 : above_rd;

  assign sum = $signed({{(SumW-8){1'b0}}, WhiteLevel - s1_pix_q})
             + SumW'(above) + SumW'(rc);
  assign bit_one = sum <= $signed({{(SumW-ThrW){1'b0}}, threshold_q});
  assign err = bit_one ? sum : sum - $signed({{(SumW-8){1'b0}}, WhiteLevel});

  assign p1 = share(err, 3'd1);
  assign p3 = share(err, 3'd3);
  assign p5 = share(err, 3'd5);
  assign p7 = share(err, 3'd7);

  assign left_sum = (ErrW+1)'(bp0) + (ErrW+1)'(p3);
  assign cur_sum  = (ErrW+1)'(bp1) + (ErrW+1)'(p5);
  assign cur      = clamp_err(cur_sum);

  assign mem_addr         = s1_col_q - 1'b1;
  assign err_wr.mem_we    = s1_fire && (s1_col_q != '0);
  assign err_wr.mem_data  = clamp_err(left_sum);
  assign err_wr.tail_we   = s1_fire && s1_last_q;
  assign err_wr.tail_data = cur;

  assign acc_new = bit_one ? (acc | (BitMsb >> pos)) : acc;
  assign cnt_new = (bit_one && cnt != '1) ? cnt + 1'b1 : cnt;
  assign emit    = (pos == 3'd7) || s1_last_q;

  always_comb begin
    rc_d  = rc_q;
    bp0_d = bp0_q;
    bp1_d = bp1_q;
    acc_d = acc_q;
    pos_d = pos_q;
    cnt_d = cnt_q;
    if (s1_fire) begin
      cnt_d = cnt_new;
      if (s1_last_q) begin
        rc_d  = '0;
        bp0_d = '0;
        bp1_d = '0;
      end else begin
        rc_d  = p7;
        bp0_d = cur;
        bp1_d = p1;
      end
      if (emit) begin
        acc_d = '0;
        pos_d = '0;
      end else begin
        acc_d = acc_new;
        pos_d = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q      <= '0;
      bp0_q     <= '0;
      bp1_q     <= '0;
      acc_q     <= '0;
      pos_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      rc_q  <= rc_d;
      bp0_q <= bp0_d;
      bp1_q <= bp1_d;
      acc_q <= acc_d;
      pos_q <= pos_d;
      cnt_q <= cnt_d;
      if (s1_fire && emit) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && emit) begin
      out_byte_q <= acc_new;
      out_last_q <= s1_last_q;
      out_cnt_q  <= cnt_new;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_cnt_q, out_byte_q};
  assign m_axis_tlast  = out_last_q;

  // ---------------- assertions ----------------
  a_row_end_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_last_q |=> out_vld_q && m_axis_tlast && pos_q == '0)
    else $error("row end did not flush the packed byte");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !s1_fire |=> s1_vld_q && $stable(s1_col_q) && $stable(s1_pix_q))
    else $error("diffusion stage lost a held pixel");

  a_start_first_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && in_start |=> s1_first_q && s1_col_q == '0)
    else $error("image start did not restart at column zero of a first row");

endmodule
